@@ hdl/gpe_pkg.sv @@
// Shared types and constants for the gamepad-to-pointer event block.
// Used by gpe_front, gpe_queue, gpe_back and gamepad_to_pointer_events.
// No dependencies.
package gpe_pkg;

    // Pointer event codes on the result side
    typedef enum logic [2:0] {
        KIND_MOVE       = 3'd0,
        KIND_WHEEL      = 3'd1,
        KIND_LEFT_DOWN  = 3'd2,
        KIND_LEFT_UP    = 3'd3,
        KIND_RIGHT_DOWN = 3'd4,
        KIND_RIGHT_UP   = 3'd5
    } t_kind;

    // Event slots of one report, in emission order
    localparam int          NUM_SLOTS  = 8;
    localparam logic [2:0]  SLOT_STICK = 3'd0;
    localparam logic [2:0]  SLOT_WHEEL = 3'd1;
    localparam logic [2:0]  SLOT_UP    = 3'd2;
    localparam logic [2:0]  SLOT_DOWN  = 3'd3;
    localparam logic [2:0]  SLOT_LEFT  = 3'd4;
    localparam logic [2:0]  SLOT_RIGHT = 3'd5;
    localparam logic [2:0]  SLOT_A     = 3'd6;
    localparam logic [2:0]  SLOT_B     = 3'd7;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0]  REG_LEFT_DZ  = 2'd0;
    localparam logic [1:0]  REG_RIGHT_DZ = 2'd1;
    localparam logic [1:0]  REG_WHEEL    = 2'd2;
    localparam logic [1:0]  REG_MAX_STEP = 2'd3;

    // Reset values
    localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET = 15'd5000;
    localparam logic [9:0]  WHEEL_RESET    = 10'd50;
    localparam logic [7:0]  MAX_STEP_RESET = 8'd255;
    localparam logic [7:0]  STEP_RESET     = 8'd5;

    // Magnitude / 2000 as (m * 33555) >> 26, exact for m up to 59073
    localparam logic [15:0] DIV2000_MUL   = 16'd33555;
    localparam int          DIV2000_SHIFT = 26;

    typedef struct packed {
        logic [14:0] left_deadzone;
        logic [14:0] right_deadzone;
        logic [9:0]  wheel_amount;
        logic [7:0]  max_step;
    } t_cfg;

    // One classified report: which slots fire plus what they need
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic signed [8:0]    stick_x;
        logic signed [8:0]    stick_y;
        logic [7:0]           step;
        logic                 wheel_neg;
        logic                 a_up;
        logic                 b_up;
    } t_report;

endpackage

@@ hdl/gpe_front.sv @@
// Front end: classifies one gamepad report into a slot mask and payload,
// and keeps step size and previous button levels. Depends on gpe_pkg.
module gpe_front import gpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic        i_connected,
    input  logic [15:0] i_left_x,
    input  logic [15:0] i_left_y,
    input  logic [15:0] i_right_y,
    input  logic        i_button_a,
    input  logic        i_button_b,
    input  logic        i_shoulder_left,
    input  logic        i_shoulder_right,
    input  logic        i_pad_up,
    input  logic        i_pad_down,
    input  logic        i_pad_left,
    input  logic        i_pad_right,
    output logic        o_push,
    output t_report     o_report
);

    logic [7:0]  r_step;
    logic        r_prev_a;
    logic        r_prev_b;
    logic        r_prev_sl;
    logic        r_prev_sr;
    logic [7:0]  n_step;

    logic [16:0] lx_ext, ly_ext, lx_mag, ly_mag;
    logic [32:0] lx_prod, ly_prod;
    logic [8:0]  qx, qy;
    logic        stick_hit;
    logic signed [16:0] ry_s, rdz_s;
    logic        wheel_up, wheel_dn;
    logic        update;

    // Magnitudes, -32768 counts as 32768
    assign lx_ext = {i_left_x[15], i_left_x};
    assign ly_ext = {i_left_y[15], i_left_y};
    assign lx_mag = lx_ext[16] ? (~lx_ext + 17'd1) : lx_ext;
    assign ly_mag = ly_ext[16] ? (~ly_ext + 17'd1) : ly_ext;

    // Divide by 2000 through the reciprocal
    assign lx_prod = 33'(lx_mag) * 33'(DIV2000_MUL);
    assign ly_prod = 33'(ly_mag) * 33'(DIV2000_MUL);
    assign qx      = {4'd0, lx_prod[DIV2000_SHIFT +: 5]};
    assign qy      = {4'd0, ly_prod[DIV2000_SHIFT +: 5]};

    assign stick_hit = (lx_mag > {2'b00, i_cfg.left_deadzone})
                    || (ly_mag > {2'b00, i_cfg.left_deadzone});

    assign ry_s     = $signed({i_right_y[15], i_right_y});
    assign rdz_s    = $signed({2'b00, i_cfg.right_deadzone});
    assign wheel_up = ry_s > rdz_s;
    assign wheel_dn = ry_s < -rdz_s;

    always_comb begin
        o_report.mask      = {i_button_b ^ r_prev_b, i_button_a ^ r_prev_a,
                              i_pad_right, i_pad_left, i_pad_down, i_pad_up,
                              wheel_up | wheel_dn, stick_hit};
        // x keeps its sign, y flips (down positive)
        o_report.stick_x   = i_left_x[15] ? (9'd0 - qx) : qx;
        o_report.stick_y   = i_left_y[15] ? qy : (9'd0 - qy);
        o_report.step      = r_step;
        o_report.wheel_neg = wheel_dn;
        o_report.a_up      = r_prev_a;
        o_report.b_up      = r_prev_b;
    end

    assign update = i_accept && i_connected;
    assign o_push = update && (|o_report.mask);

    // Lower first, then raise against the limit
    always_comb begin
        n_step = r_step;
        if (i_shoulder_left && !r_prev_sl && (n_step > 8'd1)) begin
            n_step = n_step - 8'd1;
        end
        if (i_shoulder_right && !r_prev_sr && (n_step < i_cfg.max_step)) begin
            n_step = n_step + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_RESET;
            r_prev_a  <= 1'b0;
            r_prev_b  <= 1'b0;
            r_prev_sl <= 1'b0;
            r_prev_sr <= 1'b0;
        end else if (update) begin
            r_step    <= n_step;
            r_prev_a  <= i_button_a;
            r_prev_b  <= i_button_b;
            r_prev_sl <= i_shoulder_left;
            r_prev_sr <= i_shoulder_right;
        end
    end

endmodule

@@ hdl/gpe_queue.sv @@
// Small queue of classified reports between front and back end.
// Depends on gpe_pkg. DEPTH must be a power of two, at least 2.
module gpe_queue import gpe_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_report i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_report o_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_report            r_mem [DEPTH];
    logic [IDX_W-1:0]   r_wr_ptr;
    logic [IDX_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + IDX_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + IDX_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/gpe_back.sv @@
// Back end: walks the slot mask of the head report into the result register,
// one event per cycle while that register is free. Depends on gpe_pkg.
module gpe_back import gpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [9:0]        i_wheel_amount,
    input  logic              i_q_valid,
    input  t_report           i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [2:0]        o_event_kind,
    output logic signed [8:0] o_move_x,
    output logic signed [8:0] o_move_y,
    output logic signed [10:0] o_scroll_units,
    output logic              o_last_event
);

    logic [NUM_SLOTS-1:0] r_done;
    logic                 r_out_valid;
    logic [NUM_SLOTS-1:0] pending, sel_bit, rest;
    logic [2:0]           sel;
    logic                 out_free, emit;
    t_kind                ev_kind;
    logic [8:0]           ev_x, ev_y, step9;
    logic [10:0]          ev_wheel, wheel11;

    assign pending  = i_q_valid ? (i_q_data.mask & ~r_done) : '0;
    assign sel_bit  = pending & (~pending + NUM_SLOTS'(1));
    assign rest     = pending & ~sel_bit;
    assign out_free = !r_out_valid || i_pop;
    assign emit     = out_free && (|pending);
    assign o_q_pop  = emit && (rest == '0);
    assign o_empty  = !r_out_valid;

    always_comb begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (pending[i]) begin
                sel = 3'(i);
            end
        end
    end

    assign step9   = {1'b0, i_q_data.step};
    assign wheel11 = {1'b0, i_wheel_amount};

    always_comb begin
        ev_kind  = KIND_MOVE;
        ev_x     = '0;
        ev_y     = '0;
        ev_wheel = '0;
        unique case (sel)
            SLOT_STICK: begin
                ev_x = i_q_data.stick_x;
                ev_y = i_q_data.stick_y;
            end
            SLOT_WHEEL: begin
                ev_kind  = KIND_WHEEL;
                ev_wheel = i_q_data.wheel_neg ? (11'd0 - wheel11) : wheel11;
            end
            SLOT_UP:    ev_y = 9'd0 - step9;
            SLOT_DOWN:  ev_y = step9;
            SLOT_LEFT:  ev_x = 9'd0 - step9;
            SLOT_RIGHT: ev_x = step9;
            SLOT_A:     ev_kind = i_q_data.a_up ? KIND_LEFT_UP : KIND_LEFT_DOWN;
            SLOT_B:     ev_kind = i_q_data.b_up ? KIND_RIGHT_UP : KIND_RIGHT_DOWN;
            default:    ev_kind = KIND_MOVE;
        endcase
    end

    // Result register: reload whenever it is free and an event is pending
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_event_kind   <= ev_kind;
            o_move_x       <= ev_x;
            o_move_y       <= ev_y;
            o_scroll_units <= ev_wheel;
            o_last_event   <= (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                r_done <= (rest == '0) ? '0 : (r_done | sel_bit);
            end
        end
    end

`ifndef ASSERT_OFF
    a_pending_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|pending) |=> r_out_valid)
        else $error("pending event did not reach the result register");

    a_head_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (i_q_data.mask != '0))
        else $error("queued report carries no event");

    a_motion_only_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_event_kind != KIND_MOVE)) |->
        ((o_move_x == 9'sd0) && (o_move_y == 9'sd0)))
        else $error("motion on a non-move event");
`endif

endmodule

@@ hdl/gamepad_to_pointer_events.sv @@
// Throughput: one report per cycle enters the queue while it has room; the
// back end loads one event per cycle into the result register while that is
// free, so a report with n events (1..8) holds it until its last event is
// loaded. A report that is not connected or causes no event is dropped.
// Reset (i_rst_n low, synchronous): registers to their defaults, step size 5,
// button history clear, queue and result register empty.
module gamepad_to_pointer_events import gpe_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // report side
    input  logic               push,
    output logic               full,
    input  logic               i_connected,
    input  logic [15:0]        i_left_x,
    input  logic [15:0]        i_left_y,
    input  logic [15:0]        i_right_y,
    input  logic               i_button_a,
    input  logic               i_button_b,
    input  logic               i_shoulder_left,
    input  logic               i_shoulder_right,
    input  logic               i_pad_up,
    input  logic               i_pad_down,
    input  logic               i_pad_left,
    input  logic               i_pad_right,
    // event side
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_event_kind,
    output logic signed [8:0]  o_move_x,
    output logic signed [8:0]  o_move_y,
    output logic signed [10:0] o_scroll_units,
    output logic               o_last_event
);

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    accept;
    logic    q_push, q_full, q_valid, q_pop;
    t_report front_report, q_head;

    // ------------------------------------------------------------------
    // Configuration registers: the write lands on the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_deadzone  <= LEFT_DZ_RESET;
            r_cfg.right_deadzone <= RIGHT_DZ_RESET;
            r_cfg.wheel_amount   <= WHEEL_RESET;
            r_cfg.max_step       <= MAX_STEP_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LEFT_DZ:  r_cfg.left_deadzone  <= pwdata[14:0];
                REG_RIGHT_DZ: r_cfg.right_deadzone <= pwdata[14:0];
                REG_WHEEL:    r_cfg.wheel_amount   <= pwdata[9:0];
                REG_MAX_STEP: r_cfg.max_step       <= pwdata[7:0];
                default:      r_cfg.max_step       <= r_cfg.max_step;
            endcase
        end
    end

    // Read back, zero-extended
    always_comb begin
        unique case (paddr[3:2])
            REG_LEFT_DZ:  prdata = {17'd0, r_cfg.left_deadzone};
            REG_RIGHT_DZ: prdata = {17'd0, r_cfg.right_deadzone};
            REG_WHEEL:    prdata = {22'd0, r_cfg.wheel_amount};
            REG_MAX_STEP: prdata = {24'd0, r_cfg.max_step};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: a transfer happens whenever push is high and the queue has room
    // ------------------------------------------------------------------
    assign full   = q_full;
    assign accept = push && !q_full;

    gpe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (accept),
        .i_connected      (i_connected),
        .i_left_x         (i_left_x),
        .i_left_y         (i_left_y),
        .i_right_y        (i_right_y),
        .i_button_a       (i_button_a),
        .i_button_b       (i_button_b),
        .i_shoulder_left  (i_shoulder_left),
        .i_shoulder_right (i_shoulder_right),
        .i_pad_up         (i_pad_up),
        .i_pad_down       (i_pad_down),
        .i_pad_left       (i_pad_left),
        .i_pad_right      (i_pad_right),
        .o_push           (q_push),
        .o_report         (front_report)
    );

    // ------------------------------------------------------------------
    // Decoupling queue: front and back stall independently
    // ------------------------------------------------------------------
    gpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_report),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_head)
    );

    // ------------------------------------------------------------------
    // Back end: serialize events into the result register; advance to the
    // next report as the last event of the head leaves
    // ------------------------------------------------------------------
    gpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wheel_amount (r_cfg.wheel_amount),
        .i_q_valid      (q_valid),
        .i_q_data       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_event_kind   (o_event_kind),
        .o_move_x       (o_move_x),
        .o_move_y       (o_move_y),
        .o_scroll_units (o_scroll_units),
        .o_last_event   (o_last_event)
    );

endmodule

@@ tb/gamepad_to_pointer_events_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_to_pointer_events: reports in, pointer events out.
// Depends on gpe_pkg for the event codes, register indexes and register layout.
module gamepad_to_pointer_events_tb;
    import gpe_pkg::*;

    localparam int STALL_LIMIT = 1000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 24;   // idle wait after the last expected event

    // One gamepad report as driven onto the input side
    typedef struct {
        logic               connected;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_y;
        logic               button_a;
        logic               button_b;
        logic               shoulder_left;
        logic               shoulder_right;
        logic               pad_up;
        logic               pad_down;
        logic               pad_left;
        logic               pad_right;
    } t_pad_report;

    // One pointer event as it should appear on the result side
    typedef struct {
        t_kind              kind;
        logic signed [8:0]  move_x;
        logic signed [8:0]  move_y;
        logic signed [10:0] wheel;
        logic               last;
    } t_pointer_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               push;
    logic               full;
    logic               i_connected;
    logic [15:0]        i_left_x;
    logic [15:0]        i_left_y;
    logic [15:0]        i_right_y;
    logic               i_button_a;
    logic               i_button_b;
    logic               i_shoulder_left;
    logic               i_shoulder_right;
    logic               i_pad_up;
    logic               i_pad_down;
    logic               i_pad_left;
    logic               i_pad_right;
    logic               empty;
    logic               pop;
    logic [2:0]         o_event_kind;
    logic signed [8:0]  o_move_x;
    logic signed [8:0]  o_move_y;
    logic signed [10:0] o_scroll_units;
    logic               o_last_event;

    // Predictor state: register copy, step size and the button history
    t_cfg       cfg_model;
    logic [7:0] step_now;
    logic       last_a;
    logic       last_b;
    logic       last_sl;
    logic       last_sr;

    t_pointer_event pending_events[$];

    int send_idle_pct = 14;
    int pop_idle_pct  = 14;
    int n_errors      = 0;
    int n_reports     = 0;
    int n_dropped     = 0;
    int n_events      = 0;
    int n_settings    = 0;
    int stall_count   = 0;

    gamepad_to_pointer_events uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .i_connected      (i_connected),
        .i_left_x         (i_left_x),
        .i_left_y         (i_left_y),
        .i_right_y        (i_right_y),
        .i_button_a       (i_button_a),
        .i_button_b       (i_button_b),
        .i_shoulder_left  (i_shoulder_left),
        .i_shoulder_right (i_shoulder_right),
        .i_pad_up         (i_pad_up),
        .i_pad_down       (i_pad_down),
        .i_pad_left       (i_pad_left),
        .i_pad_right      (i_pad_right),
        .empty            (empty),
        .pop              (pop),
        .o_event_kind     (o_event_kind),
        .o_move_x         (o_move_x),
        .o_move_y         (o_move_y),
        .o_scroll_units   (o_scroll_units),
        .o_last_event     (o_last_event)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_pointer_event make_event(input t_kind k, input int mx, input int my,
                                                  input int wd);
        t_pointer_event e;
        e.kind   = k;
        e.move_x = mx;
        e.move_y = my;
        e.wheel  = wd;
        e.last   = 1'b0;
        return e;
    endfunction

    // Work out the events of one accepted report, in emission order, and
    // advance the button history and step size the way the block does.
    function automatic void predict_events(input t_pad_report r);
        t_pointer_event burst[$];
        int lx, ly, ry, step, ldz, rdz, wamt;
        if (!r.connected)
            return;     // drop: no event, no state change
        lx   = r.left_x;
        ly   = r.left_y;
        ry   = r.right_y;
        step = step_now;
        ldz  = cfg_model.left_deadzone;
        rdz  = cfg_model.right_deadzone;
        wamt = cfg_model.wheel_amount;

        // Stick move: integer division truncates toward zero, as required
        if ((lx < 0 ? -lx : lx) > ldz || (ly < 0 ? -ly : ly) > ldz)
            burst.push_back(make_event(KIND_MOVE, lx / 2000, (-ly) / 2000, 0));

        if (ry > rdz)
            burst.push_back(make_event(KIND_WHEEL, 0, 0, wamt));
        else if (ry < -rdz)
            burst.push_back(make_event(KIND_WHEEL, 0, 0, -wamt));

        // D-pad moves use the step size from before this report's shoulders
        if (r.pad_up)    burst.push_back(make_event(KIND_MOVE, 0, -step, 0));
        if (r.pad_down)  burst.push_back(make_event(KIND_MOVE, 0, step, 0));
        if (r.pad_left)  burst.push_back(make_event(KIND_MOVE, -step, 0, 0));
        if (r.pad_right) burst.push_back(make_event(KIND_MOVE, step, 0, 0));

        if (r.button_a && !last_a)      burst.push_back(make_event(KIND_LEFT_DOWN, 0, 0, 0));
        else if (!r.button_a && last_a) burst.push_back(make_event(KIND_LEFT_UP, 0, 0, 0));
        if (r.button_b && !last_b)      burst.push_back(make_event(KIND_RIGHT_DOWN, 0, 0, 0));
        else if (!r.button_b && last_b) burst.push_back(make_event(KIND_RIGHT_UP, 0, 0, 0));
        last_a = r.button_a;
        last_b = r.button_b;

        // Lower first (floor 1), then raise only while below max_step
        if (r.shoulder_left && !last_sl && step_now > 8'd1)
            step_now--;
        last_sl = r.shoulder_left;
        if (r.shoulder_right && !last_sr && step_now < cfg_model.max_step)
            step_now++;
        last_sr = r.shoulder_right;

        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                pending_events.push_back(burst[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_pad_report blank_report();
        t_pad_report r;
        r = '{default: '0};
        r.connected = 1'b1;
        return r;
    endfunction

    // Axis value biased toward the deadzone edge and the rails
    function automatic logic [15:0] axis_value(input int dz);
        int m;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: begin
                m = dz + int'($urandom_range(2)) - 1;
                if (m < 0) m = 0;
                if (m > 32767) m = 32767;
                if ($urandom_range(1)) m = -m;
                return m[15:0];
            end
            2: begin
                m = int'($urandom_range(400)) - 200;
                return m[15:0];
            end
            default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    function automatic t_pad_report random_report();
        t_pad_report r;
        r.connected = ($urandom_range(99) >= 10);
        r.left_x    = axis_value(cfg_model.left_deadzone);
        r.left_y    = axis_value(cfg_model.left_deadzone);
        r.right_y   = axis_value(cfg_model.right_deadzone);
        {r.button_a, r.button_b, r.shoulder_left, r.shoulder_right,
         r.pad_up, r.pad_down, r.pad_left, r.pad_right} = 8'($urandom);
        return r;
    endfunction

    // Send one report. Entered and left at a falling edge; push stays high
    // on exit so back-to-back reports never drop it in between.
    task automatic send_report(input t_pad_report r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push             <= 1'b1;
        i_connected      <= r.connected;
        i_left_x         <= r.left_x;
        i_left_y         <= r.left_y;
        i_right_y        <= r.right_y;
        i_button_a       <= r.button_a;
        i_button_b       <= r.button_b;
        i_shoulder_left  <= r.shoulder_left;
        i_shoulder_right <= r.shoulder_right;
        i_pad_up         <= r.pad_up;
        i_pad_down       <= r.pad_down;
        i_pad_left       <= r.pad_left;
        i_pad_right      <= r.pad_right;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_events(r);
        n_reports++;
        if (!r.connected) n_dropped++;
        @(negedge i_clk);
    endtask

    // Hold push low, let every expected event come out, then wait out the drain
    // time before the registers move.
    task automatic settle();
        push <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register, then read it back. Leaves psel high for the caller.
    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            REG_LEFT_DZ:  mask = 32'h7fff;
            REG_RIGHT_DZ: mask = 32'h7fff;
            REG_WHEEL:    mask = 32'h03ff;
            default:      mask = 32'h00ff;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_LEFT_DZ:  cfg_model.left_deadzone  = value[14:0];
            REG_RIGHT_DZ: cfg_model.right_deadzone = value[14:0];
            REG_WHEEL:    cfg_model.wheel_amount   = value[9:0];
            default:      cfg_model.max_step       = value[7:0];
        endcase
        @(negedge i_clk);
        penable <= 1'b0;    // read setup follows the write directly
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback expected %0d, actual %0d",
                     $time, idx, value & mask, prdata & mask);
            n_errors++;
        end
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int ldz, input int rdz, input int wamt, input int mstep);
        settle();
        program_reg(REG_LEFT_DZ, ldz);
        program_reg(REG_RIGHT_DZ, rdz);
        program_reg(REG_WHEEL, wamt);
        program_reg(REG_MAX_STEP, mstep);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Deadzone edges, stick rails and wheel thresholds at reset settings
    task automatic test_stick_and_wheel();
        t_pad_report r;
        r = blank_report();
        r.left_x  = 16'sd7849;      // exactly at the deadzone: no move
        r.left_y  = -16'sd7849;
        r.right_y = 16'sd5000;      // exactly at the deadzone: no wheel
        send_report(r);
        r.left_x  = -16'sd7850;     // just past: truncates toward zero
        r.left_y  = 16'sd7850;
        r.right_y = -16'sd5001;
        send_report(r);
        r.left_x  = 16'sh7fff;
        r.left_y  = 16'sh8000;      // most negative counts as 32768
        r.right_y = 16'sh7fff;
        send_report(r);
        r.left_x  = 16'sh8000;
        r.left_y  = 16'sh7fff;
        r.right_y = 16'sh8000;
        send_report(r);
    endtask

    // Every event source in one report, then both buttons released
    task automatic test_buttons_and_pad();
        t_pad_report r;
        r = blank_report();
        r.left_x   = 16'sd20000;
        r.right_y  = 16'sd9000;
        r.pad_up   = 1'b1;
        r.pad_down = 1'b1;
        r.pad_left = 1'b1;
        r.pad_right = 1'b1;
        r.button_a = 1'b1;
        r.button_b = 1'b1;
        send_report(r);
        r = blank_report();
        send_report(r);
    endtask

    // A report that is not connected must leave the button history alone
    task automatic test_disconnected();
        t_pad_report r;
        r = blank_report();
        r.connected      = 1'b0;
        r.left_x         = 16'sh8000;
        r.right_y        = 16'sh7fff;
        r.button_a       = 1'b1;
        r.shoulder_right = 1'b1;
        r.pad_down       = 1'b1;
        send_report(r);
        r.connected = 1'b1;         // now the A press and shoulder edge count
        send_report(r);
    endtask

    // Drive the step down to its floor, then pin the ceiling at zero
    task automatic test_step_limits();
        t_pad_report r;
        r = blank_report();
        r.pad_up = 1'b1;
        for (int i = 0; i < 10; i++) begin
            r.shoulder_left = (i % 2 == 0);
            send_report(r);
        end
        apply_settings(LEFT_DZ_RESET, RIGHT_DZ_RESET, WHEEL_RESET, 0);
        r = blank_report();
        r.pad_right      = 1'b1;
        r.shoulder_right = 1'b1;
        send_report(r);
        r.shoulder_right = 1'b0;
        send_report(r);
    endtask

    // Deadzones at both extremes, wheel amount at zero and at its top
    task automatic test_deadzone_extremes();
        t_pad_report r;
        apply_settings(0, 0, 0, 1);
        r = blank_report();
        r.left_x  = 16'sd1;
        r.right_y = 16'sd1;         // wheel event carrying zero
        send_report(r);
        r = blank_report();         // all zero: nothing exceeds a zero deadzone
        send_report(r);
        apply_settings(32767, 32767, 1023, MAX_STEP_RESET);
        r = blank_report();
        r.left_x  = 16'sh8000;
        r.left_y  = 16'sh7fff;
        r.right_y = 16'sh8000;
        send_report(r);
        r.right_y = 16'sh7fff;
        send_report(r);
    endtask

    task automatic run_random_phase(input int ldz, input int rdz, input int wamt,
                                    input int mstep, input int count, input int idle_pct);
        apply_settings(ldz, rdz, wamt, mstep);
        send_idle_pct = idle_pct;
        pop_idle_pct  = idle_pct;
        repeat (count) send_report(random_report());
        send_idle_pct = 14;
        pop_idle_pct  = 14;
    endtask

    task automatic test_random_traffic();
        run_random_phase(LEFT_DZ_RESET, RIGHT_DZ_RESET, WHEEL_RESET, MAX_STEP_RESET, 60, 14);
        run_random_phase(0, 0, 1, 1, 60, 14);
        run_random_phase(32767, 32767, 1023, 255, 60, 14);
        // no idling on either side for this whole stretch
        run_random_phase($urandom_range(32767), $urandom_range(32767),
                         $urandom_range(1023, 1), $urandom_range(12, 2), 70, 0);
        run_random_phase($urandom_range(32767), $urandom_range(32767), 0, 0, 60, 14);
        run_random_phase($urandom_range(32767), $urandom_range(32767),
                         $urandom_range(1023), $urandom_range(255), 70, 14);
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop, per-field compare against the oldest entry
    // ------------------------------------------------------------------

    always @(negedge i_clk)
        pop <= ($urandom_range(99) >= pop_idle_pct);

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pointer_event want;
        if (i_rst_n && pop && !empty) begin
            n_events++;
            if (pending_events.size() == 0) begin
                $display("%0t: event expected none, actual kind %0d", $time, o_event_kind);
                n_errors++;
            end else begin
                want = pending_events.pop_front();
                compare_field("event_kind", want.kind, o_event_kind);
                compare_field("move_x", want.move_x, o_move_x);
                compare_field("move_y", want.move_y, o_move_y);
                compare_field("scroll_units", want.wheel, o_scroll_units);
                compare_field("last_event", want.last, o_last_event);
            end
        end
    end

    // Watchdog: any transfer on either side or the register port restarts it
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable) || !i_rst_n)
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // hold every input at a known value from time zero
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        push             = 1'b0;
        pop              = 1'b0;
        i_connected      = 1'b0;
        i_left_x         = '0;
        i_left_y         = '0;
        i_right_y        = '0;
        i_button_a       = 1'b0;
        i_button_b       = 1'b0;
        i_shoulder_left  = 1'b0;
        i_shoulder_right = 1'b0;
        i_pad_up         = 1'b0;
        i_pad_down       = 1'b0;
        i_pad_left       = 1'b0;
        i_pad_right      = 1'b0;

        cfg_model.left_deadzone  = LEFT_DZ_RESET;
        cfg_model.right_deadzone = RIGHT_DZ_RESET;
        cfg_model.wheel_amount   = WHEEL_RESET;
        cfg_model.max_step       = MAX_STEP_RESET;
        step_now = STEP_RESET;
        last_a   = 1'b0;
        last_b   = 1'b0;
        last_sl  = 1'b0;
        last_sr  = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_stick_and_wheel();
        test_buttons_and_pad();
        test_disconnected();
        test_step_limits();
        test_deadzone_extremes();
        test_random_traffic();

        settle();
        if (pending_events.size() != 0) begin
            $display("%0t: %0d events never arrived", $time, pending_events.size());
            n_errors++;
        end
        $display("Sent %0d reports (%0d not connected) under %0d register settings;",
                 n_reports, n_dropped, n_settings);
        $display("checked %0d pointer events, %0d mismatches.", n_events, n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gpe_pkg.sv
hdl/gpe_front.sv
hdl/gpe_queue.sv
hdl/gpe_back.sv
hdl/gamepad_to_pointer_events.sv
tb/gamepad_to_pointer_events_tb.sv
